[design/wsdf_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and codes for the WebSocket frame deframer.
// No dependencies; imported by the deframer and its port checker.
package wsdf_pkg;

  // Width of the payload length counter (16..64).
  localparam int LENGTH_BITS = 64;

  localparam int BYTE_W   = 8;
  localparam int OPCODE_W = 4;
  localparam int LEN_W    = 64;

  // out_tdata: data_byte, fin_flag, frame_opcode, mask_flag, payload_length
  localparam int OUT_FIELDS_W = BYTE_W + 1 + OPCODE_W + 1 + LEN_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Largest length the counter can hold, in full length width.
  localparam logic [LEN_W-1:0] LENGTH_LIMIT = {LEN_W{1'b1}} >> (LEN_W - LENGTH_BITS);

  // Header byte decode constants.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  // Result kind carried on tuser.
  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } result_kind_t;

endpackage

[design/websocket_frame_deframer.sv]
`timescale 1ns / 1ps
// WebSocket (RFC 6455) receive-side deframer: byte stream in, header and
// unmasked payload results out. Depends on wsdf_pkg.

// Accepts one byte per clock, every clock, as long as the result register is
// empty or being drained in the same cycle. Each byte is decoded combinationally
// between the input handshake and a one-entry result register, so a
// result appears on out_* the cycle after the byte that caused it. Header
// bytes produce no result until the header (including any extended length
// and mask key) is complete; then one header result is issued (kind 0),
// followed by one result per payload byte (kind 1) with the mask removed.
// tlast marks the final payload byte, or the header itself for an empty
// frame. The byte after the last payload byte starts the next frame. RSV
// bits and opcode rules are not checked; lengths above the counter range
// saturate.
module websocket_frame_deframer
  import wsdf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] byte_in
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] data_byte, [8] fin_flag,
                                            // [12:9] frame_opcode, [13] mask_flag,
                                            // [77:14] payload_length, rest zero
  output logic                  out_tuser,  // [0] result_kind
  output logic                  out_tlast   // last_in_frame
);

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXT     = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             ext_left_r, ext_left_nxt;
  logic [2:0]             key_left_r, key_left_nxt;
  logic                   fin_r, fin_nxt;
  logic [OPCODE_W-1:0]    opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             kpos_r, kpos_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;

  logic                   emit;
  result_kind_t           res_kind;
  logic [BYTE_W-1:0]      res_data;
  logic                   res_last;
  logic                   after_len;
  logic                   finish;
  logic [LEN_W-1:0]       len_cand;
  logic [LEN_W-1:0]       len_sat;
  logic [BYTE_W-1:0]      key_byte;
  logic                   in_fire;

  logic                   out_valid_r;
  result_kind_t           out_kind_r;
  logic [BYTE_W-1:0]      out_data_r;
  logic                   out_fin_r;
  logic [OPCODE_W-1:0]    out_opcode_r;
  logic                   out_mask_r;
  logic [LEN_W-1:0]       out_len_r;
  logic                   out_last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign key_byte = key_r[8*(3-kpos_r) +: 8];
  assign len_sat  = ((len_cand >> LENGTH_BITS) != '0) ? LENGTH_LIMIT : len_cand;

  always_comb begin
    phase_nxt    = phase_r;
    ext_left_nxt = ext_left_r;
    key_left_nxt = key_left_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    masked_nxt   = masked_r;
    len_nxt      = len_r;
    key_nxt      = key_r;
    kpos_nxt     = kpos_r;
    left_nxt     = left_r;
    emit         = 1'b0;
    res_kind     = KIND_HEADER;
    res_data     = '0;
    res_last     = 1'b0;
    after_len    = 1'b0;
    finish       = 1'b0;
    len_cand     = len_r;

    case (phase_r)
      PH_SECOND: begin
        masked_nxt = in_tdata[7];
        key_nxt    = '0;
        kpos_nxt   = '0;
        if (in_tdata[6:0] == LEN7_EXT16 || in_tdata[6:0] == LEN7_EXT64) begin
          ext_left_nxt = (in_tdata[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          len_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else begin
          len_cand  = {{(LEN_W-7){1'b0}}, in_tdata[6:0]};
          len_nxt   = len_cand;
          after_len = 1'b1;
        end
      end
      PH_EXT: begin
        len_cand = {len_r[LEN_W-9:0], in_tdata};
        len_nxt  = len_cand;
        if (ext_left_r <= 4'd1) begin
          ext_left_nxt = '0;
          after_len    = 1'b1;
        end else begin
          ext_left_nxt = ext_left_r - 4'd1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], in_tdata};
        if (key_left_r <= 3'd1) begin
          key_left_nxt = '0;
          finish       = 1'b1;
        end else begin
          key_left_nxt = key_left_r - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        kpos_nxt = kpos_r + 2'd1;
        left_nxt = (left_r == '0) ? left_r : left_r - LENGTH_BITS'(1);
        emit     = 1'b1;
        res_kind = KIND_PAYLOAD;
        res_data = masked_r ? (in_tdata ^ key_byte) : in_tdata;
        res_last = (left_r == '0) || (left_r == LENGTH_BITS'(1));
        if (res_last) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        // first header byte; unused phase codes land here too
        fin_nxt    = in_tdata[7];
        opcode_nxt = in_tdata[OPCODE_W-1:0];
        phase_nxt  = PH_SECOND;
      end
    endcase

    if (after_len) begin
      if (masked_nxt) begin
        key_left_nxt = KEY_BYTES;
        phase_nxt    = PH_KEY;
      end else begin
        finish = 1'b1;
      end
    end

    if (finish) begin
      len_nxt   = len_sat;
      left_nxt  = len_sat[LENGTH_BITS-1:0];
      kpos_nxt  = '0;
      emit      = 1'b1;
      res_kind  = KIND_HEADER;
      res_data  = '0;
      res_last  = (len_sat == '0);
      phase_nxt = res_last ? PH_FIRST : PH_PAYLOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      ext_left_r <= '0;
      key_left_r <= '0;
      fin_r      <= 1'b0;
      opcode_r   <= '0;
      masked_r   <= 1'b0;
      len_r      <= '0;
      key_r      <= '0;
      kpos_r     <= '0;
      left_r     <= '0;
    end else if (in_fire) begin
      phase_r    <= phase_nxt;
      ext_left_r <= ext_left_nxt;
      key_left_r <= key_left_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      masked_r   <= masked_nxt;
      len_r      <= len_nxt;
      key_r      <= key_nxt;
      kpos_r     <= kpos_nxt;
      left_r     <= left_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind_r   <= res_kind;
      out_data_r   <= res_data;
      out_fin_r    <= fin_nxt;
      out_opcode_r <= opcode_nxt;
      out_mask_r   <= masked_nxt;
      out_len_r    <= len_nxt;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, out_len_r, out_mask_r,
                       out_opcode_r, out_fin_r, out_data_r};

endmodule

[design/wsdf_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsdf_pkg.
module wsdf_checker
  import wsdf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  out_tlast
);

  logic [LEN_W-1:0] len_w;
  assign len_w = out_tdata[BYTE_W+6 +: LEN_W];

  // result register comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // input side only waits on a full, stalled result register
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input stalled with room in the result register");

  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_HEADER |->
      out_tdata[BYTE_W-1:0] == '0 && out_tlast == (len_w == '0))
    else $error("header result: nonzero data or wrong last for its length");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PAYLOAD |-> len_w != '0)
    else $error("payload byte in a zero-length frame");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

[sim/websocket_frame_deframer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer: streams frame bytes
// with random gaps and output stalls, predicts every result and compares it.
// Depends on wsdf_pkg and the deframer RTL.
module websocket_frame_deframer_tb;
  import wsdf_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_BODY
  } parse_phase_t;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  typedef struct packed {
    result_kind_t      kind;
    logic [7:0]        data;
    logic              fin;
    logic [3:0]        opcode;
    logic              masked;
    logic [LEN_W-1:0]  length;
    logic              last;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;    // [7:0] byte_in
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [7:0] data_byte, [8] fin_flag,
                                           // [12:9] frame_opcode, [13] mask_flag,
                                           // [77:14] payload_length
  logic                  out_tuser;        // [0] result_kind
  logic                  out_tlast;

  websocket_frame_deframer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Predicted parser state
  parse_phase_t     phase = PH_HDR0;
  logic [3:0]       ext_left = '0;
  logic [2:0]       key_left = '0;
  logic             hdr_fin = 1'b0;
  logic [3:0]       hdr_opcode = '0;
  logic             hdr_masked = 1'b0;
  logic [LEN_W-1:0] hdr_length = '0;
  logic [31:0]      mask_key = '0;
  logic [1:0]       key_idx = '0;
  logic [LEN_W-1:0] body_left = '0;

  frame_result_t results_due[$];
  int unsigned   mismatches = 0;
  int unsigned   bytes_sent = 0;
  bit            calm = 1'b0;       // no idling on either side while set
  int unsigned   rx_hold_req = 0;   // long receiver hold-off, in cycles
  int unsigned   rx_stall = 0;

  initial forever #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned idle_span();
    if (calm || $urandom_range(0, 99) < 60) return 0;
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic string describe(frame_result_t r);
    return $sformatf("kind=%0d data=%02h fin=%0b op=%0h mask=%0b len=%0h last=%0b",
                     r.kind, r.data, r.fin, r.opcode, r.masked, r.length, r.last);
  endfunction

  task automatic push_result(input result_kind_t kind, input logic [7:0] data,
                             input logic last);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.fin    = hdr_fin;
    r.opcode = hdr_opcode;
    r.masked = hdr_masked;
    r.length = hdr_length;
    r.last   = last;
    results_due.push_back(r);
  endtask

  task automatic header_done();
    if (hdr_length > LENGTH_LIMIT) hdr_length = LENGTH_LIMIT;
    body_left = hdr_length;
    key_idx = '0;
    push_result(KIND_HEADER, 8'h00, hdr_length == 0);
    phase = (hdr_length == 0) ? PH_HDR0 : PH_BODY;
  endtask

  task automatic length_done();
    if (hdr_masked) begin
      key_left = KEY_BYTES;
      phase = PH_KEY;
    end else begin
      header_done();
    end
  endtask

  // Advance the predicted parser by one accepted byte.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] key_byte;
    case (phase)
      PH_HDR1: begin
        hdr_masked = b[7];
        mask_key = '0;
        key_idx = '0;
        if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
          ext_left = (b[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          hdr_length = '0;
          phase = PH_EXTLEN;
        end else begin
          hdr_length = {{(LEN_W-7){1'b0}}, b[6:0]};
          length_done();
        end
      end
      PH_EXTLEN: begin
        hdr_length = {hdr_length[LEN_W-9:0], b};
        if (ext_left <= 1) begin
          ext_left = '0;
          length_done();
        end else begin
          ext_left--;
        end
      end
      PH_KEY: begin
        mask_key = {mask_key[23:0], b};
        if (key_left <= 1) begin
          key_left = '0;
          header_done();
        end else begin
          key_left--;
        end
      end
      PH_BODY: begin
        // first key byte sits in the top bits
        key_byte = hdr_masked ? mask_key[8*(3 - key_idx) +: 8] : 8'h00;
        key_idx++;
        if (body_left != 0) body_left--;
        push_result(KIND_PAYLOAD, b ^ key_byte, body_left == 0);
        if (body_left == 0) phase = PH_HDR0;
      end
      default: begin
        hdr_fin = b[7];
        hdr_opcode = b[3:0];
        phase = PH_HDR1;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_span();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] first, input logic masked,
                            input len_form_t form, input logic [LEN_W-1:0] length,
                            input logic [31:0] key, input int unsigned body_bytes);
    logic [6:0] len7;
    case (form)
      LEN_EXT16: len7 = LEN7_EXT16;
      LEN_EXT64: len7 = LEN7_EXT64;
      default:   len7 = length[6:0];
    endcase
    send_byte(first);
    send_byte({masked, len7});
    if (form == LEN_EXT16)
      for (int i = 1; i >= 0; i--) send_byte(length[8*i +: 8]);
    if (form == LEN_EXT64)
      for (int i = 7; i >= 0; i--) send_byte(length[8*i +: 8]);
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (body_bytes) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Zero-length frames: the header request itself carries tlast.
  task automatic test_empty_frames();
    send_frame(8'hFF, 1'b0, LEN_SHORT, 64'd0, 32'h0000_0000, 0);
    send_frame(8'h00, 1'b1, LEN_SHORT, 64'd0, 32'hFFFF_FFFF, 0);
  endtask

  // Key index wraps past four bytes; RSV bits set on the first byte.
  task automatic test_mask_rotation();
    send_frame(8'h21, 1'b1, LEN_SHORT, 64'd5, 32'h8001_A55A, 5);
  endtask

  task automatic test_extended_16();
    send_frame(8'h88, 1'b0, LEN_EXT16, 64'd1, 32'h0, 1);
  endtask

  // Receiver holds off while the sender keeps offering a long frame.
  task automatic test_backpressure();
    calm = 1'b1;
    rx_hold_req = 300;
    send_frame(8'h82, 1'b1, LEN_EXT16, 64'd80, $urandom, 80);
    calm = 1'b0;
  endtask

  task automatic test_random_stream();
    len_form_t        form;
    logic [LEN_W-1:0] length;
    int unsigned      pick;
    while (bytes_sent < 1430) begin
      calm = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        form = LEN_SHORT;
        pick = $urandom_range(0, 99);
        if (pick < 10)      length = '0;
        else if (pick < 16) length = LEN_W'($urandom_range(123, 125));
        else                length = LEN_W'($urandom_range(1, 12));
      end else if (pick < 85) begin
        form = LEN_EXT16;
        length = LEN_W'($urandom_range(0, 40));
      end else begin
        form = LEN_EXT64;
        length = LEN_W'($urandom_range(0, 24));
      end
      send_frame(8'($urandom), 1'($urandom), form, length, $urandom, 32'(length));
    end
    calm = 1'b0;
  endtask

  // 8-byte length with the reserved top bit set; the frame never completes,
  // so this has to run last.
  task automatic test_reserved_length_bit();
    send_frame(8'h82, 1'b1, LEN_EXT64, {LEN_W{1'b1}}, $urandom, 8);
  endtask

  always @(posedge clk) begin
    if (rx_hold_req != 0) begin
      rx_stall = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_stall != 0) begin
      out_tready <= 1'b0;
      rx_stall--;
    end else begin
      rx_stall = idle_span();
      if (rx_stall == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        rx_stall--;
      end
    end
  end

  always @(posedge clk) begin
    frame_result_t seen;
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.kind   = result_kind_t'(out_tuser);
      seen.data   = out_tdata[7:0];
      seen.fin    = out_tdata[8];
      seen.opcode = out_tdata[12:9];
      seen.masked = out_tdata[13];
      seen.length = out_tdata[77:14];
      seen.last   = out_tlast;
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: unexpected result %s", $realtime, describe(seen));
      end else begin
        want = results_due.pop_front();
        if (seen.kind !== want.kind || seen.data !== want.data ||
            seen.fin !== want.fin || seen.opcode !== want.opcode ||
            seen.masked !== want.masked || seen.length !== want.length ||
            seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: mismatch, expected %s, got %s", $realtime,
                     describe(want), describe(seen));
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_frames();
    test_mask_rotation();
    test_extended_16();
    test_backpressure();
    test_random_stream();
    test_reserved_length_bit();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
